/* rtl/core/tdrm_pkg.sv */
// Shared widths, defaults and control types for the temporal delta run marker.
package tdrm_pkg;

  localparam int unsigned CFG_W            = 19;
  localparam int unsigned PIXEL_W          = 16;
  localparam int unsigned DIFF_W           = 17;
  localparam int unsigned TDATA_IN_W       = 16;
  localparam int unsigned TDATA_OUT_W      = 24;
  localparam int unsigned FRAME_PIXELS_RST = 262144;
  localparam int unsigned MAX_PIXELS_DEF   = 262144;
  localparam int unsigned PIXEL_BITS_DEF   = 16;

  typedef struct packed {
    logic accept;
    logic first;
  } stage_ctrl_t;

endpackage

/* rtl/core/tdrm_frame_mem.sv */
// Previous-frame memory: one port, read-first, registered read data.
module tdrm_frame_mem #(
  parameter int unsigned DEPTH = tdrm_pkg::MAX_PIXELS_DEF,
  parameter int unsigned AW    = $clog2(tdrm_pkg::MAX_PIXELS_DEF),
  parameter int unsigned DW    = tdrm_pkg::PIXEL_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q       <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/tdrm_marker.sv */
// Difference stage and output register with repeat marking.
module tdrm_marker #(
  parameter int unsigned PIXEL_BITS = tdrm_pkg::PIXEL_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tdrm_pkg::stage_ctrl_t                 ctrl_i,
  input  logic [PIXEL_BITS-1:0]                 pix_i,
  input  logic [PIXEL_BITS-1:0]                 prev_i,
  output logic                                  free_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  out_new_o,
  output logic signed [tdrm_pkg::DIFF_W-1:0]    out_diff_o
);

  localparam int unsigned EW = (PIXEL_BITS > tdrm_pkg::DIFF_W) ? PIXEL_BITS : tdrm_pkg::DIFF_W;

  logic                          s1_valid_q;
  logic                          s1_first_q;
  logic [PIXEL_BITS-1:0]         s1_pix_q;
  logic                          out_valid_q;
  logic                          out_new_q;
  logic [tdrm_pkg::DIFF_W-1:0]   out_diff_q;
  logic                          have_q;
  logic [tdrm_pkg::DIFF_W-1:0]   last_q;
  logic [EW-1:0]                 diff_full;
  logic [tdrm_pkg::DIFF_W-1:0]   diff;
  logic                          fresh;
  logic                          advance;

  assign diff_full = EW'(s1_pix_q) - EW'(prev_i);
  assign diff      = diff_full[tdrm_pkg::DIFF_W-1:0];
  assign fresh     = !have_q || (diff != last_q);
  assign advance   = s1_valid_q && (s1_first_q || !out_valid_q || out_ready_i);
  assign free_o    = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
    end else if (ctrl_i.accept) begin
      s1_valid_q <= 1'b1;
      s1_first_q <= ctrl_i.first;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      s1_pix_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      last_q      <= '0;
    end else if (advance && !s1_first_q) begin
      out_valid_q <= 1'b1;
      if (fresh) begin
        have_q <= 1'b1;
        last_q <= diff;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !s1_first_q) begin
      out_new_q  <= fresh;
      out_diff_q <= diff;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_new_o   = out_new_q;
  assign out_diff_o  = out_diff_q;

endmodule

/* rtl/core/temporal_delta_run_marker_core.sv */
// Temporal delta run marker: each pixel stored and compared with the previous frame.
// Takes one pixel per cycle in raster order unless the output stalls and, after the
// first frame, returns one registered transaction per pixel: the difference to the
// co-located pixel of the previous frame (m_axis_tdata) and a flag that is 1 when
// that difference is new and 0 when it repeats the last one (m_axis_tuser). The rate
// is set by the single previous-frame memory port, which reads the old pixel and
// writes the new one at the same address in the same cycle. The first frame after
// reset fills the memory and returns nothing. The frame size register takes effect
// on the next pixel; 0 acts as 1 and values above MAX_PIXELS act as MAX_PIXELS.
module temporal_delta_run_marker_core #(
  parameter int unsigned MAX_PIXELS = tdrm_pkg::MAX_PIXELS_DEF,
  parameter int unsigned PIXEL_BITS = tdrm_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tdrm_pkg::CFG_W-1:0]       cfg_data_i,      // frame_pixels
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [tdrm_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i,  // [15:0] pixel
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [tdrm_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,  // [16:0] difference, zero pad
  output logic                             m_axis_tuser_o   // [0] new_value
);

  localparam int unsigned AW = $clog2(MAX_PIXELS);
  localparam int unsigned SW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CW = (SW > tdrm_pkg::CFG_W) ? SW : tdrm_pkg::CFG_W;
  localparam int unsigned SizeRstInt = (tdrm_pkg::FRAME_PIXELS_RST > MAX_PIXELS) ?
                                       MAX_PIXELS : tdrm_pkg::FRAME_PIXELS_RST;
  localparam logic [SW-1:0] SizeRst = SW'(SizeRstInt);

  logic [SW-1:0]          size_q;
  logic [AW-1:0]          pos_q;
  logic                   first_q;
  logic [CW-1:0]          cfg_ext;
  logic [SW-1:0]          pos_next;
  logic [PIXEL_BITS-1:0]  pix;
  logic [PIXEL_BITS-1:0]  prev;
  logic                   accept;
  logic                   free;
  logic                   out_new;
  logic signed [tdrm_pkg::DIFF_W-1:0] out_diff;
  tdrm_pkg::stage_ctrl_t  ctrl;

  generate
    if (PIXEL_BITS >= tdrm_pkg::PIXEL_W) begin : g_pix_wide
      assign pix = PIXEL_BITS'(s_axis_tdata_i[tdrm_pkg::PIXEL_W-1:0]);
    end else begin : g_pix_narrow
      assign pix = s_axis_tdata_i[PIXEL_BITS-1:0];
    end
  endgenerate

  assign cfg_ready_o     = 1'b1;
  assign cfg_ext         = CW'(cfg_data_i);
  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;
  assign pos_next        = SW'(pos_q) + SW'(1);
  assign ctrl.accept     = accept;
  assign ctrl.first      = first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeRst;
    end else if (cfg_valid_i) begin
      if (cfg_ext == '0) begin
        size_q <= SW'(1);
      end else if (cfg_ext > CW'(MAX_PIXELS)) begin
        size_q <= SW'(MAX_PIXELS);
      end else begin
        size_q <= SW'(cfg_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
    end else if (accept) begin
      if (pos_next >= size_q) begin
        pos_q   <= '0;
        first_q <= 1'b0;
      end else begin
        pos_q <= pos_next[AW-1:0];
      end
    end
  end

  tdrm_frame_mem #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (pos_q),
    .wdata_i (pix),
    .rdata_o (prev)
  );

  tdrm_marker #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_marker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .pix_i       (pix),
    .prev_i      (prev),
    .free_o      (free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_new_o   (out_new),
    .out_diff_o  (out_diff)
  );

  assign m_axis_tdata_o = {{(tdrm_pkg::TDATA_OUT_W - tdrm_pkg::DIFF_W){1'b0}}, out_diff};
  assign m_axis_tuser_o = out_new;

endmodule

/* rtl/core/tdrm_checker.sv */
// Port-level checks for the temporal delta run marker, bound to the top level.
module tdrm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [tdrm_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);

  logic                        seen_q;
  logic [tdrm_pkg::DIFF_W-1:0] last_q;
  logic                        out_acc;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (out_acc && m_axis_tuser_o) begin
      seen_q <= 1'b1;
      last_q <= m_axis_tdata_o[tdrm_pkg::DIFF_W-1:0];
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  a_first_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !seen_q |-> m_axis_tuser_o)
    else $error("first result not marked new");

  a_repeat_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[tdrm_pkg::DIFF_W-1:0] == last_q)
    else $error("repeat differs from last new value");

  a_new_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o && seen_q |->
      m_axis_tdata_o[tdrm_pkg::DIFF_W-1:0] != last_q)
    else $error("new value equals last new value");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[tdrm_pkg::TDATA_OUT_W-1:tdrm_pkg::DIFF_W] == '0)
    else $error("tdata padding not zero");

endmodule

bind temporal_delta_run_marker_core tdrm_checker u_tdrm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* verif/tdrm_delta_checker.sv */
// Checker for the temporal delta run marker: predicts each difference and marker and compares.
`timescale 1ns / 1ps

module tdrm_delta_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [tdrm_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [tdrm_pkg::TDATA_IN_W-1:0]  s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [tdrm_pkg::TDATA_OUT_W-1:0] m_tdata_i,
  input  logic                             m_tuser_i,
  output int unsigned                      pending_o,
  output int unsigned                      mismatch_count_o
);

  typedef logic [tdrm_pkg::CFG_W-1:0]       cfg_t;
  typedef logic [tdrm_pkg::TDATA_OUT_W-1:0] tdata_out_t;

  typedef struct packed {
    logic                        new_value;
    logic [tdrm_pkg::DIFF_W-1:0] difference;
  } delta_t;

  delta_t                      expected_deltas[$];
  bit [tdrm_pkg::PIXEL_W-1:0]  prior_frame [tdrm_pkg::MAX_PIXELS_DEF];
  cfg_t                        frame_size;
  int unsigned                 position;
  bit                          first_frame;
  bit                          have_delta;
  logic [tdrm_pkg::DIFF_W-1:0] last_delta;
  int unsigned                 mismatches;

  function automatic int unsigned active_size(input cfg_t raw);
    if (raw == '0) return 1;
    if (raw > tdrm_pkg::MAX_PIXELS_DEF) return tdrm_pkg::MAX_PIXELS_DEF;
    return raw;
  endfunction

  task automatic predict_delta(input logic [tdrm_pkg::PIXEL_W-1:0] pixel);
    logic [tdrm_pkg::DIFF_W-1:0] delta;
    bit                          fresh;
    delta_t                      entry;
    if (position >= tdrm_pkg::MAX_PIXELS_DEF) position = 0;
    if (!first_frame) begin
      delta = {1'b0, pixel} - {1'b0, prior_frame[position]};
      fresh = !have_delta || (delta != last_delta);
      if (fresh) begin
        last_delta = delta;
        have_delta = 1'b1;
      end
      entry.new_value  = fresh;
      entry.difference = delta;
      expected_deltas.insert(expected_deltas.size(), entry);
    end
    prior_frame[position] = pixel;
    position++;
    if (position >= active_size(frame_size)) begin
      position = 0;
      first_frame = 1'b0;
    end
  endtask

  task automatic check_delta(input tdata_out_t data, input logic flag);
    delta_t     want;
    tdata_out_t want_data;
    if (expected_deltas.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result tdata %h tuser %b", $time, data, flag);
    end else begin
      want = expected_deltas.pop_front();
      want_data = tdata_out_t'(want.difference);
      if (data !== want_data || flag !== want.new_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: difference exp %h got %h, new_value exp %b got %b",
                   $time, want_data, data, want.new_value, flag);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_deltas.delete();
      frame_size = cfg_t'(tdrm_pkg::FRAME_PIXELS_RST);
      position = 0;
      first_frame = 1'b1;
      have_delta = 1'b0;
      last_delta = '0;
      mismatches = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) frame_size = cfg_data_i;
      if (s_tvalid_i && s_tready_i) predict_delta(s_tdata_i[tdrm_pkg::PIXEL_W-1:0]);
      if (m_tvalid_i && m_tready_i) check_delta(m_tdata_i, m_tuser_i);
      pending_o <= expected_deltas.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

/* verif/tb.sv */
// Testbench top for the temporal delta run marker: pixel stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb;

  typedef logic [tdrm_pkg::PIXEL_W-1:0] pixel_t;
  typedef logic [tdrm_pkg::CFG_W-1:0]   cfg_t;

  localparam int unsigned FILL_PIXELS   = 24;
  localparam int unsigned TARGET_PIXELS = 900;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam cfg_t SIZE_RAW_MAX = '1;
  localparam pixel_t EDGE_PIXELS [12] = '{
    16'h1234, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003
  };

  typedef enum logic [1:0] {PIX_RANDOM, PIX_FLAT, PIX_JITTER, PIX_RAIL} pixel_mode_e;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  cfg_t                             cfg_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [tdrm_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [tdrm_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic                             m_tuser;

  int unsigned  pending_results;
  int unsigned  mismatch_count;
  int unsigned  pixels_sent = 0;
  int unsigned  size_writes = 0;
  int unsigned  results_seen = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_left = 0;
  int unsigned  flow_left = 0;
  bit           steady_feed = 1'b1;
  pixel_mode_e  pixel_mode = PIX_RANDOM;
  pixel_t       flat_level = '0;

  always #10 clk_i = ~clk_i;

  temporal_delta_run_marker_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  tdrm_delta_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tuser_i        (m_tuser),
    .pending_o        (pending_results),
    .mismatch_count_o (mismatch_count)
  );

  function automatic int unsigned feed_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic pixel_t next_pixel();
    case (pixel_mode)
      PIX_FLAT:   return flat_level;
      PIX_JITTER: return flat_level + pixel_t'($urandom_range(0, 1));
      PIX_RAIL:   return $urandom_range(0, 1) ? {tdrm_pkg::PIXEL_W{1'b1}} :
                                                 {tdrm_pkg::PIXEL_W{1'b0}};
      default:    return pixel_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input pixel_t value);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk_i); while (!s_tready);
    pixels_sent++;
    gap = steady_feed ? 0 : feed_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the feed until every difference is back and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_frame_size(input cfg_t raw);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= raw;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_writes++;
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (flow_left != 0) begin
      m_tready <= 1'b1;
      flow_left--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:9]:   begin flow_left = $urandom_range(20, 150); m_tready <= 1'b1; end
        [10:13]: begin hold_left = $urandom_range(9, 29);   m_tready <= 1'b0; end
        [14:39]: begin hold_left = $urandom_range(0, 2);    m_tready <= 1'b0; end
        default: m_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
      if (m_tvalid && m_tready) results_seen++;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[temporal_delta_run_marker_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned span;
    int unsigned count;
    cfg_t        raw;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill the first frame at the clamped size, then cut it short
    steady_feed = 1'b0;
    set_frame_size(SIZE_RAW_MAX);
    send_pixel('0);
    repeat (FILL_PIXELS - 2) send_pixel(next_pixel());
    send_pixel('1);
    set_frame_size('0);
    foreach (EDGE_PIXELS[i]) send_pixel(EDGE_PIXELS[i]);

    // never grow the frame past what the first frame wrote
    span = FILL_PIXELS + 1;
    while (pixels_sent < TARGET_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       raw = '0;
        1:       raw = cfg_t'(1);
        2:       raw = cfg_t'(span);
        default: raw = cfg_t'($urandom_range(1, span));
      endcase
      set_frame_size(raw);
      pixel_mode = pixel_mode_e'($urandom_range(0, 3));
      flat_level = pixel_t'($urandom);
      steady_feed = ($urandom_range(0, 3) == 0);
      count = $urandom_range(1, 4 * span);
      repeat (count) send_pixel(next_pixel());
    end

    settle();
    $display("Covered %0d pixels across %0d frame size writes (sizes 0 to %0d and the raw max).",
             pixels_sent, size_writes, span);
    $display("Checked %0d differences with their repeat markers.", results_seen);
    if (mismatch_count == 0) begin
      $display("[temporal_delta_run_marker_core] OK");
    end else begin
      $display("[temporal_delta_run_marker_core] ERROR");
    end
    $finish;
  end

endmodule

/* temporal_delta_run_marker_core.f */
rtl/core/tdrm_pkg.sv
rtl/core/tdrm_frame_mem.sv
rtl/core/tdrm_marker.sv
rtl/core/temporal_delta_run_marker_core.sv
rtl/core/tdrm_checker.sv
verif/tdrm_delta_checker.sv
verif/tb.sv
